>>> rtl/core/bc5_pkg.sv
// ----------------------------------------------------------------------------
// bc5_pkg
// Shared types, constants and the helper function of the two-channel block
// decoder with twiddled addressing.
// ----------------------------------------------------------------------------
package bc5_pkg;

  localparam int unsigned ENDPT_W    = 8;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned BLOCK_W    = 2 * HALF_W;
  localparam int unsigned TEXELS     = 16;
  localparam int unsigned TEXEL_IDX_W = $clog2(TEXELS);
  localparam int unsigned IDX_BASE   = 2 * ENDPT_W;

  localparam int unsigned ADDR_W     = 21;
  localparam int unsigned IN_BLK_W   = 5;
  localparam int unsigned BASE_W     = ADDR_W - IN_BLK_W;

  localparam int unsigned CFG_W      = 9;
  localparam int unsigned OUT_DATA_W = 40;

  // floor(n / 7) for n < 5461 as (n * RECIP7) >> RECIP7_SHIFT
  localparam int unsigned NUM_W        = 11;
  localparam int unsigned RECIP7_SHIFT = 14;
  localparam int unsigned RECIP7_W     = 12;
  localparam logic [RECIP7_W-1:0] RECIP7 = 12'd2341;
  localparam logic [INDEX_W-1:0]  IDX_MAX = 3'd7;

  localparam logic [TEXEL_IDX_W-1:0] LAST_TEXEL = 4'd15;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  // morton offset of texel k inside the 4x4 block, in bytes
  function automatic logic [IN_BLK_W-1:0] in_blk_offset(input logic [TEXEL_IDX_W-1:0] k);
    return {k[1], k[3], k[0], k[2], 1'b0};
  endfunction

endpackage

>>> rtl/core/bc5_block_decoder_twiddled_top.sv
// ----------------------------------------------------------------------------
// bc5_block_decoder_twiddled_top
// Two-channel compressed block decoder emitting sixteen texels per block,
// each with its twiddled byte address.
//
// Usage:
//   s_axis carries one 16-byte block per transaction: bits 63:0 the red half,
//   bits 127:64 the green half. m_axis carries one texel per transaction, in
//   row order; tlast marks the sixteenth texel of a block.
//   Sizes are written through cfg_we_i / cfg_addr_i / cfg_wdata_i while the
//   block is idle; the side of the morton square follows the smaller size.
//   Path: a block taken on s_axis passes the input buffer and the current
//   block register before its first texel is loaded into the output register.
//   Throughput: one texel per cycle unless m_axis_tready_i stalls the output,
//   set by the single output register. A one-block input buffer takes the next
//   block while the current one is still being emitted.
//   Reset clears all valid flags, sets both sizes to one and puts the block
//   position at row 0, column 0.
//   When m_axis_tready_i is low the output register holds its texel, the
//   current block stops, and s_axis_tready_o drops once the buffer is full.
// ----------------------------------------------------------------------------
module bc5_block_decoder_twiddled_top #(
  parameter int unsigned MAX_SIDE_BLOCKS = 256,
  parameter int unsigned MORTON_BITS     = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  bc5_pkg::cfg_reg_e                cfg_addr_i,
  input  logic [bc5_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // block_low, block_high
  input  logic [bc5_pkg::BLOCK_W-1:0]      s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // texel_red, texel_green, byte_address, zero pad
  output logic [bc5_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);
  import bc5_pkg::*;

  logic                   hold_valid_q, hold_valid_d;
  logic [BLOCK_W-1:0]     hold_data_q;
  logic                   cur_valid_q, cur_valid_d;
  logic [BLOCK_W-1:0]     cur_data_q;
  logic [BASE_W-1:0]      cur_base_q;
  logic [TEXEL_IDX_W-1:0] cur_k_q, cur_k_d;
  logic                   out_valid_q, out_valid_d;
  logic [ENDPT_W-1:0]     out_red_q, out_green_q;
  logic [ADDR_W-1:0]      out_addr_q;
  logic                   out_last_q;

  logic                   in_acc, out_free, cur_adv, cur_done, cur_load;
  logic [BASE_W-1:0]      base;
  logic [HALF_W-1:0]      cur_lo, cur_hi;
  logic [INDEX_W-1:0]     red_idx, green_idx;
  logic [ENDPT_W-1:0]     red_val, green_val;

  assign s_axis_tready_o = !hold_valid_q;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign cur_adv  = cur_valid_q && out_free;
  assign cur_done = cur_adv && (cur_k_q == LAST_TEXEL);
  assign cur_load = hold_valid_q && (!cur_valid_q || cur_done);

  bc5_addr_gen #(
    .MAX_SIDE_BLOCKS(MAX_SIDE_BLOCKS),
    .MORTON_BITS    (MORTON_BITS)
  ) u_addr_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (cur_load),
    .base_o     (base)
  );

  assign cur_lo    = cur_data_q[HALF_W-1:0];
  assign cur_hi    = cur_data_q[BLOCK_W-1:HALF_W];
  assign red_idx   = cur_lo[IDX_BASE + INDEX_W*cur_k_q +: INDEX_W];
  assign green_idx = cur_hi[IDX_BASE + INDEX_W*cur_k_q +: INDEX_W];

  bc5_lerp7 u_lerp_red (
    .e0_i   (cur_lo[ENDPT_W-1:0]),
    .e1_i   (cur_lo[2*ENDPT_W-1:ENDPT_W]),
    .idx_i  (red_idx),
    .value_o(red_val)
  );

  bc5_lerp7 u_lerp_green (
    .e0_i   (cur_hi[ENDPT_W-1:0]),
    .e1_i   (cur_hi[2*ENDPT_W-1:ENDPT_W]),
    .idx_i  (green_idx),
    .value_o(green_val)
  );

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (in_acc) begin
      hold_valid_d = 1'b1;
    end else if (cur_load) begin
      hold_valid_d = 1'b0;
    end

    cur_valid_d = cur_valid_q;
    cur_k_d     = cur_k_q;
    if (cur_load) begin
      cur_valid_d = 1'b1;
      cur_k_d     = '0;
    end else if (cur_done) begin
      cur_valid_d = 1'b0;
      cur_k_d     = '0;
    end else if (cur_adv) begin
      cur_k_d = cur_k_q + TEXEL_IDX_W'(1);
    end

    out_valid_d = out_valid_q;
    if (cur_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      cur_valid_q  <= 1'b0;
      cur_k_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      cur_valid_q  <= cur_valid_d;
      cur_k_q      <= cur_k_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hold_data_q <= s_axis_tdata_i;
    end
    if (cur_load) begin
      cur_data_q <= hold_data_q;
      cur_base_q <= base;
    end
    if (cur_adv) begin
      out_red_q   <= red_val;
      out_green_q <= green_val;
      out_addr_q  <= {cur_base_q, in_blk_offset(cur_k_q)};
      out_last_q  <= (cur_k_q == LAST_TEXEL);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_addr_q, out_green_q, out_red_q});

`ifndef SYNTH
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && !cur_valid_q) |=> cur_valid_q)
    else $error("buffered block not moved into empty decoder");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_k_q != '0) |-> cur_valid_q)
    else $error("texel count running without a block");

  a_last_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_addr_q[IN_BLK_W-1:0] == in_blk_offset(LAST_TEXEL)))
    else $error("last texel carries wrong in-block offset");
`endif

endmodule

>>> rtl/core/bc5_lerp7.sv
// ----------------------------------------------------------------------------
// bc5_lerp7
// One channel of the palette: floor((e0*(7-i) + e1*i) / 7) in exact integer
// arithmetic, the division done as a reciprocal multiply.
// ----------------------------------------------------------------------------
module bc5_lerp7 (
  input  logic [bc5_pkg::ENDPT_W-1:0] e0_i,
  input  logic [bc5_pkg::ENDPT_W-1:0] e1_i,
  input  logic [bc5_pkg::INDEX_W-1:0] idx_i,
  output logic [bc5_pkg::ENDPT_W-1:0] value_o
);
  import bc5_pkg::*;

  localparam int unsigned ProdW = NUM_W + RECIP7_W;

  logic [INDEX_W-1:0] inv_idx;
  logic [NUM_W-1:0]   num;
  logic [ProdW-1:0]   prod;

  always_comb begin
    inv_idx = IDX_MAX - idx_i;
    num     = NUM_W'(e0_i) * NUM_W'(inv_idx) + NUM_W'(e1_i) * NUM_W'(idx_i);
    prod    = ProdW'(num) * ProdW'(RECIP7);
    value_o = prod[RECIP7_SHIFT +: ENDPT_W];
  end

endmodule

>>> rtl/core/bc5_addr_gen.sv
// ----------------------------------------------------------------------------
// bc5_addr_gen
// Size registers, block row/column counters and the twiddled base address
// of the block at the current position.
// ----------------------------------------------------------------------------
module bc5_addr_gen #(
  parameter int unsigned MAX_SIDE_BLOCKS = 256,
  parameter int unsigned MORTON_BITS     = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  bc5_pkg::cfg_reg_e           cfg_addr_i,
  input  logic [bc5_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        step_i,
  output logic [bc5_pkg::BASE_W-1:0]  base_o
);
  import bc5_pkg::*;

  localparam int unsigned CntW  = (MAX_SIDE_BLOCKS > 1) ? $clog2(MAX_SIDE_BLOCKS) : 1;
  localparam int unsigned SizeW = $clog2(MAX_SIDE_BLOCKS + 1);
  localparam int unsigned SbW   = $clog2(MORTON_BITS + 1);
  localparam int unsigned ExtW  = CntW + MORTON_BITS;
  localparam int unsigned MortW = 2 * MORTON_BITS;
  localparam int unsigned WideW = CntW + 1 + MortW;

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic [CntW-1:0]  col_q, col_d;
  logic [CntW-1:0]  row_q, row_d;

  logic [SizeW-1:0] eff_w, eff_h, min_side;
  logic [SbW-1:0]   side_bits;
  logic [CntW-1:0]  mask;
  logic [ExtW-1:0]  col_x, row_x;
  logic [MortW-1:0] morton;
  logic [CntW:0]    squares;
  logic [WideW-1:0] base_wide;
  logic [CntW:0]    col_inc, row_inc;

  always_comb begin
    if (width_q == '0) begin
      eff_w = SizeW'(1);
    end else if (32'(width_q) > MAX_SIDE_BLOCKS) begin
      eff_w = SizeW'(MAX_SIDE_BLOCKS);
    end else begin
      eff_w = SizeW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = SizeW'(1);
    end else if (32'(height_q) > MAX_SIDE_BLOCKS) begin
      eff_h = SizeW'(MAX_SIDE_BLOCKS);
    end else begin
      eff_h = SizeW'(height_q);
    end
    min_side = (eff_w < eff_h) ? eff_w : eff_h;

    side_bits = '0;
    for (int b = 1; b <= int'(MORTON_BITS); b++) begin
      if (32'(min_side) >= (32'd1 << b)) begin
        side_bits = SbW'(b);
      end
    end

    for (int b = 0; b < int'(CntW); b++) begin
      mask[b] = (32'(b) < 32'(side_bits));
    end
    col_x = ExtW'(col_q & mask);
    row_x = ExtW'(row_q & mask);
    for (int b = 0; b < int'(MORTON_BITS); b++) begin
      morton[2*b]   = row_x[b];
      morton[2*b+1] = col_x[b];
    end

    squares   = (CntW+1)'(col_q >> side_bits) + (CntW+1)'(row_q >> side_bits);
    base_wide = (WideW'(squares) << {side_bits, 1'b0}) + WideW'(morton);
    base_o    = BASE_W'(base_wide);
  end

  // position of the next block
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    col_inc = (CntW+1)'(col_q) + (CntW+1)'(1);
    row_inc = (CntW+1)'(row_q) + (CntW+1)'(1);
    if (step_i) begin
      if (32'(col_inc) >= 32'(eff_w)) begin
        col_d = '0;
        if (32'(row_inc) >= 32'(eff_h)) begin
          row_d = '0;
        end else begin
          row_d = CntW'(row_inc);
        end
      end else begin
        col_d = CntW'(col_inc);
      end
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_WIDTH:  width_d  = cfg_wdata_i;
        CFG_HEIGHT: height_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

>>> verif/bc5_block_decoder_twiddled_top_tb.sv
// ----------------------------------------------------------------------------
// bc5_block_decoder_twiddled_top_tb
// Self-checking bench for the two-channel block decoder. Blocks go in on
// s_axis. A predictor decodes each accepted block into its sixteen texels,
// works out their twiddled addresses and tracks the block position. Texels
// seen on m_axis are compared in order against those predictions. Sizes are
// changed between phases, extremes and out-of-range values included, with
// random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module bc5_block_decoder_twiddled_top_tb;
  import bc5_pkg::*;

  localparam int unsigned MAX_SIDE    = 256;
  localparam int unsigned MORTON_BITS = 5;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned N_PHASES    = 12;
  localparam int unsigned PHASE_ITEMS = 34;

  localparam logic [CFG_W-1:0] PHASE_W [N_PHASES] =
    '{9'd0, 9'd2, 9'd4, 9'd3, 9'd256, 9'd7, 9'd40, 9'd511, 9'd1, 9'd17, 9'd300, 9'd256};
  localparam logic [CFG_W-1:0] PHASE_H [N_PHASES] =
    '{9'd0, 9'd2, 9'd3, 9'd5, 9'd2, 9'd1, 9'd33, 9'd300, 9'd7, 9'd64, 9'd511, 9'd256};

  typedef struct packed {
    logic [ENDPT_W-1:0] red;
    logic [ENDPT_W-1:0] green;
    logic [ADDR_W-1:0]  addr;
    logic               last;
  } texel_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  cfg_reg_e              cfg_addr_i      = CFG_WIDTH;
  logic [CFG_W-1:0]      cfg_wdata_i     = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [BLOCK_W-1:0]    s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;

  logic [BLOCK_W-1:0] pending_blocks[$];
  texel_t             texels_due[$];
  logic [CFG_W-1:0]   width_cfg   = 9'd1;
  logic [CFG_W-1:0]   height_cfg  = 9'd1;
  int unsigned        blk_col     = 0;
  int unsigned        blk_row     = 0;
  int unsigned        fail_count  = 0;
  bit                 blk_taken   = 1'b0;
  bit                 texel_taken = 1'b0;
  bit                 no_gaps     = 1'b0;
  int unsigned        send_gap    = 0;
  int unsigned        recv_gap    = 0;
  int unsigned        hold_left   = 0;

  bc5_block_decoder_twiddled_top #(
    .MAX_SIDE_BLOCKS(MAX_SIDE),
    .MORTON_BITS    (MORTON_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned clamp_size(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic int unsigned interleave(int unsigned v);
    int unsigned r = 0;
    for (int b = 0; b < MORTON_BITS; b++) r |= ((v >> b) & 1) << (2 * b);
    return r;
  endfunction

  function automatic logic [ENDPT_W-1:0] blend7(int unsigned e0, int unsigned e1,
                                               int unsigned i);
    return ENDPT_W'((e0 * (7 - i) + e1 * i) / 7);
  endfunction

  // expands one block into its texels and advances the block position
  function automatic void decode_block(logic [BLOCK_W-1:0] blk);
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
    int unsigned w, h, m, sb, side, base, x, y, ri, gi, pos;
    texel_t t;
    lo = blk[HALF_W-1:0];
    hi = blk[BLOCK_W-1:HALF_W];
    w = clamp_size(width_cfg);
    h = clamp_size(height_cfg);
    m = (w < h) ? w : h;
    sb = 0;
    while (sb < MORTON_BITS && (2 << sb) <= m) sb++;
    side = 1 << sb;
    base = interleave(blk_row & (side - 1)) | (interleave(blk_col & (side - 1)) << 1);
    base = (base + ((blk_col >> sb) + (blk_row >> sb)) * side * side) << 5;
    for (int k = 0; k < TEXELS; k++) begin
      x = k & 3;
      y = k >> 2;
      ri = 32'(lo[IDX_BASE + 3 * k +: INDEX_W]);
      gi = 32'(hi[IDX_BASE + 3 * k +: INDEX_W]);
      pos = ((y & 1) | ((y & 2) << 1) | ((x & 1) << 1) | ((x & 2) << 2)) << 1;
      t.red = blend7(lo[7:0], lo[15:8], ri);
      t.green = blend7(hi[7:0], hi[15:8], gi);
      t.addr = ADDR_W'(base + pos);
      t.last = (k == TEXELS - 1);
      texels_due.push_back(t);
    end
    blk_col++;
    if (blk_col >= w) begin
      blk_col = 0;
      blk_row++;
      if (blk_row >= h) blk_row = 0;
    end
  endfunction

  // prediction and checking
  always @(posedge clk_i) begin
    texel_t got;
    texel_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_WIDTH) width_cfg = cfg_wdata_i;
        else height_cfg = cfg_wdata_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        decode_block(s_axis_tdata_i);
        blk_taken = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        texel_taken = 1'b1;
        got.red   = m_axis_tdata_o[7:0];
        got.green = m_axis_tdata_o[15:8];
        got.addr  = m_axis_tdata_o[36:16];
        got.last  = m_axis_tlast_o;
        if (texels_due.size() == 0) begin
          $error("texel transaction with nothing pending: %p", got);
          fail_count++;
        end else begin
          want = texels_due.pop_front();
          if (got.red !== want.red) begin
            $error("texel_red expected %0d actual %0d", want.red, got.red);
            fail_count++;
          end
          if (got.green !== want.green) begin
            $error("texel_green expected %0d actual %0d", want.green, got.green);
            fail_count++;
          end
          if (got.addr !== want.addr) begin
            $error("byte_address expected %0h actual %0h", want.addr, got.addr);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last_texel expected %0d actual %0d", want.last, got.last);
            fail_count++;
          end
        end
      end
    end
  end

  // block driver
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid_i && !blk_taken)) begin
      blk_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        s_axis_tdata_i  <= pending_blocks.pop_front();
        s_axis_tvalid_i <= 1'b1;
        send_gap = no_gaps ? 0 : $urandom_range(0, 3);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // texel receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (texel_taken) begin
        texel_taken = 1'b0;
        recv_gap = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // long output stall
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  task automatic drain();
    while (pending_blocks.size() != 0 || s_axis_tvalid_i || texels_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_size(cfg_reg_e sel, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= sel;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [HALF_W-1:0] ramp_half(logic [7:0] e0, logic [7:0] e1,
                                                 int unsigned offs);
    logic [HALF_W-1:0] v;
    v[15:0] = {e1, e0};
    for (int k = 0; k < TEXELS; k++) v[IDX_BASE + 3 * k +: 3] = INDEX_W'((k + offs) % 8);
    return v;
  endfunction

  function automatic logic [HALF_W-1:0] rand_half();
    logic [HALF_W-1:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) begin
      v[7:0]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      v[15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return v;
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // endpoint and index extremes at reset sizes
    pending_blocks.push_back('0);
    pending_blocks.push_back('1);
    pending_blocks.push_back({ramp_half(8'd0, 8'd255, 7), ramp_half(8'd255, 8'd0, 7)});
    pending_blocks.push_back({ramp_half(8'd200, 8'd200, 3), ramp_half(8'd1, 8'd254, 5)});
    for (int o = 0; o < 8; o++)
      pending_blocks.push_back({ramp_half(8'd255, 8'd0, o), ramp_half(8'd0, 8'd255, o)});
    pending_blocks.push_back({ramp_half(8'd128, 8'd127, 1), ramp_half(8'd127, 8'd128, 2)});
    drain();

    // zero sizes act as one, oversize saturates, square side caps
    set_size(CFG_WIDTH, 9'd0);
    set_size(CFG_HEIGHT, 9'd511);
    for (int o = 0; o < 4; o++)
      pending_blocks.push_back({ramp_half(8'd0, 8'd255, o), ramp_half(8'd255, 8'd1, o)});
    drain();
    set_size(CFG_WIDTH, 9'd256);
    set_size(CFG_HEIGHT, 9'd256);
    for (int o = 0; o < 4; o++)
      pending_blocks.push_back({ramp_half(8'd10, 8'd90, o), ramp_half(8'd90, 8'd10, o)});
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      set_size(CFG_WIDTH, PHASE_W[p]);
      set_size(CFG_HEIGHT, PHASE_H[p]);
      no_gaps = (p % 4 == 1);
      if (p == 2) hold_left <= HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++)
        pending_blocks.push_back({rand_half(), rand_half()});
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
